// File: hdl/assert_macros.svh
// Assertion macros shared by the shuffle engine modules.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on a named clock, disabled while reset is low.
`define FYS_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the project clock and reset.
`define FYS_ASSERT(name, prop, msg) \
  `FYS_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

// File: hdl/fys_pkg.sv
// Shared types and constants for the Fisher-Yates shuffle engine.
// No dependencies; imported by fys_divider and fisher_yates_shuffle.
package fys_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int WORD_W      = 32;
  localparam int SIZE_W      = 7;
  localparam int OFF_W       = 16;
  localparam int VAL_W       = 17;
  localparam int SLOT_W      = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 16;
  localparam int STEP_W      = $clog2(WORD_W);

  localparam logic [SIZE_W-1:0]    SET_SIZE_RST    = 7'd64;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_OFFSET = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD_POS,
    ST_RD_PICK,
    ST_WR_POS,
    ST_WR_PICK,
    ST_RD_ZERO,
    ST_EMIT_ZERO
  } fys_state_e;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } fys_div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } fys_div_rsp_t;

endpackage

// File: hdl/fys_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fys_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/fys_divider.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on fys_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fys_divider import fys_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  fys_div_req_t req_i,
  output fys_div_rsp_t rsp_o
);

  logic              active_q, active_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [WORD_W-1:0] dvd_q, dvd_d;
  logic [CNT_W-1:0]  dsr_q, dsr_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W:0]    trial;

  always_comb begin
    active_d = active_q;
    step_d   = step_q;
    dvd_d    = dvd_q;
    dsr_d    = dsr_q;
    rem_d    = rem_q;
    done_d   = 1'b0;
    trial    = {rem_q, dvd_q[WORD_W-1]};
    if (req_i.start) begin
      active_d = 1'b1;
      step_d   = '0;
      dvd_d    = req_i.dividend;
      dsr_d    = req_i.divisor;
      rem_d    = '0;
    end else if (active_q) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = CNT_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = CNT_W'(trial);
      end
      dvd_d  = {dvd_q[WORD_W-2:0], 1'b0};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(WORD_W - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

  `FYS_ASSERT(a_rem_below_divisor, done_q |-> (rem_q < dsr_q), "remainder not below divisor")
  `FYS_ASSERT(a_done_ends_run, done_q |-> !active_q, "done raised while still stepping")
  `FYS_ASSERT(a_done_single, done_q |=> !done_q, "done held longer than one cycle")

endmodule

// File: hdl/fisher_yates_shuffle.sv
// Per request: the divider takes 32 remainder steps, then the table is read at the position and the pick
// and both entries are written back swapped; at position one a slot-zero result follows.
// A new request is taken only while busy is low; with one entry in use the divider is skipped.
// Results are registered and shown for one cycle on strobe_o.
// Reset: set_size 64, offset 0, table reads as identity through per-entry valid bits.
// Depends on fys_pkg, fys_divider, fys_ram and assert_macros.svh.
`include "assert_macros.svh"
module fisher_yates_shuffle import fys_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [WORD_W-1:0]    random_word_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 strobe_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic signed [VAL_W-1:0] drawn_value_o,
  output logic                 last_o
);

  function automatic logic [CNT_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [CNT_W-1:0] r;
    if (s == '0) begin
      r = CNT_W'(1);
    end else if (int'(s) > MAX_ENTRIES) begin
      r = CNT_W'(MAX_ENTRIES);
    end else begin
      r = CNT_W'(s);
    end
    return r;
  endfunction

  fys_state_e state_q, state_d;

  logic [SIZE_W-1:0]      set_size_q;
  logic [OFF_W-1:0]       offset_q;
  logic [IDX_W-1:0]       cnt_q;
  logic [IDX_W-1:0]       pos_q;
  logic [IDX_W-1:0]       pick_q;
  logic [IDX_W-1:0]       held_q;
  logic [IDX_W-1:0]       rd_addr_q;
  logic [MAX_ENTRIES-1:0] valid_q;
  logic                   strobe_q;
  logic [SLOT_W-1:0]      slot_q;
  logic [VAL_W-1:0]       value_q;
  logic                   last_q;

  logic [CNT_W-1:0] eff;
  logic [IDX_W-1:0] pos_sel;
  logic [IDX_W-1:0] entry;
  logic [VAL_W-1:0] value_calc;
  logic             accept;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [IDX_W-1:0] ram_rdata;

  fys_div_req_t div_req;
  fys_div_rsp_t div_rsp;

  assign eff    = eff_size(set_size_q);
  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // guard the counter against an out-of-range value
  assign pos_sel = ((CNT_W'(cnt_q) >= eff) || (cnt_q == '0)) ? IDX_W'(eff - CNT_W'(1)) : cnt_q;

  // never-written entries read as their own index
  assign entry = valid_q[rd_addr_q] ? ram_rdata : rd_addr_q;

  assign value_calc = {{(VAL_W - IDX_W){1'b0}}, entry}
                    + {{(VAL_W - OFF_W){offset_q[OFF_W-1]}}, offset_q};

  assign div_req.start    = accept && (eff > CNT_W'(1));
  assign div_req.dividend = random_word_i;
  assign div_req.divisor  = CNT_W'(pos_sel) + CNT_W'(1);

  fys_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  fys_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = entry;
    ram_raddr = pos_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (eff > CNT_W'(1)) ? ST_DIV : ST_RD_ZERO;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_RD_POS;
        end
      end
      ST_RD_POS: begin
        state_d = ST_RD_PICK;
      end
      ST_RD_PICK: begin
        ram_raddr = pick_q;
        state_d   = ST_WR_POS;
      end
      ST_WR_POS: begin
        ram_we  = 1'b1;
        state_d = ST_WR_PICK;
      end
      ST_WR_PICK: begin
        ram_we    = 1'b1;
        ram_waddr = pick_q;
        ram_wdata = held_q;
        state_d   = (pos_q == IDX_W'(1)) ? ST_RD_ZERO : ST_IDLE;
      end
      ST_RD_ZERO: begin
        ram_raddr = '0;
        state_d   = ST_EMIT_ZERO;
      end
      ST_EMIT_ZERO: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q <= SET_SIZE_RST;
      offset_q   <= '0;
      cnt_q      <= IDX_W'(eff_size(SET_SIZE_RST) - CNT_W'(1));
      valid_q    <= '0;
      strobe_q   <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SET_SIZE: begin
            set_size_q <= cfg_wdata_i[SIZE_W-1:0];
            cnt_q      <= IDX_W'(eff_size(cfg_wdata_i[SIZE_W-1:0]) - CNT_W'(1));
          end
          CFG_DRAW_OFFSET: begin
            offset_q <= cfg_wdata_i[OFF_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (state_q == ST_WR_POS) begin
        strobe_q <= 1'b1;
      end
      if (state_q == ST_WR_PICK && pos_q != IDX_W'(1)) begin
        cnt_q <= pos_q - IDX_W'(1);
      end
      if (state_q == ST_EMIT_ZERO) begin
        // permutation complete: back to identity, reload the counter
        strobe_q <= 1'b1;
        valid_q  <= '0;
        cnt_q    <= IDX_W'(eff - CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= ram_raddr;
    if (accept) begin
      pos_q <= pos_sel;
    end
    if (state_q == ST_DIV && div_rsp.done) begin
      pick_q <= IDX_W'(div_rsp.rem);
    end
    if (state_q == ST_RD_PICK) begin
      held_q <= entry;
    end
    if (state_q == ST_WR_POS) begin
      slot_q  <= SLOT_W'(pos_q);
      value_q <= value_calc;
      last_q  <= 1'b0;
    end
    if (state_q == ST_EMIT_ZERO) begin
      slot_q  <= '0;
      value_q <= value_calc;
      last_q  <= 1'b1;
    end
  end

  assign strobe_o      = strobe_q;
  assign slot_o        = slot_q;
  assign drawn_value_o = $signed(value_q);
  assign last_o        = last_q;

  `FYS_ASSERT(a_strobe_src, strobe_o |-> ($past(state_q) == ST_WR_POS || $past(state_q) == ST_EMIT_ZERO), "result strobe without emit step")
  `FYS_ASSERT(a_done_in_div, div_rsp.done |-> (state_q == ST_DIV), "divider finished outside wait state")
  `FYS_ASSERT(a_last_slot_zero, (strobe_o && last_o) |-> (slot_o == '0), "closing result not at slot zero")

endmodule
